// ===== hdl/mabc_pkg.sv =====
// ---------------------------------------------------------------------------
// mabc_pkg: shared types and helpers for the mur absorbing boundary block
// fixed point word types, history row layout, register codes, saturation
// ---------------------------------------------------------------------------
package mabc_pkg;

    localparam int WORD_W      = 32;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = 64;
    localparam int FRAC_BITS   = 27;
    localparam int RND_W       = PROD_W + 1 - FRAC_BITS;
    localparam int CFG_INDEX_W = 2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RND_W-1:0]  rnd_t;

    // q4.27 half-lsb used for round half up
    localparam logic signed [PROD_W:0] ROUND_BIAS = 65'sh0400_0000;

    localparam acc_t SAT_MAX = 40'sh00_7FFF_FFFF;
    localparam acc_t SAT_MIN = -40'sh00_8000_0000;

    // one time step of history: depths 0..2, depth 0 in the low bits
    typedef struct packed {
        word_t m2;
        word_t m1;
        word_t m0;
    } hist_step_t;

    // one memory row per edge cell: newest step in the low bits
    typedef struct packed {
        hist_step_t q1;
        hist_step_t q0;
    } hist_row_t;

    localparam int HIST_ROW_W = $bits(hist_row_t);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WEIGHT_ZERO = 2'd0,
        REG_WEIGHT_ONE  = 2'd1,
        REG_WEIGHT_TWO  = 2'd2
    } cfg_index_t;

    // load strobes for the datapath stages
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
        logic load_d;
        logic load_e;
    } stage_en_t;

    function automatic word_t sat_word(acc_t v);
        word_t r;
        if (v > SAT_MAX)
        begin
            r = word_t'(SAT_MAX);
        end
        else if (v < SAT_MIN)
        begin
            r = word_t'(SAT_MIN);
        end
        else
        begin
            r = word_t'(v);
        end
        return r;
    endfunction

endpackage

// ===== hdl/mur_second_order_abc.sv =====
// ---------------------------------------------------------------------------
// mur_second_order_abc: second-order mur absorbing boundary update
// streams edge cells of a 2d tmz grid and returns the new edge field
// ---------------------------------------------------------------------------
// One transaction in gives one transaction out. The block takes one edge cell
// per clock unless an output stall, a same-cell hazard or the clearing pass
// holds it off; stage a reads the history ram, then pre-sum, multiply, round,
// final sum into the output register. Each cell keeps a 192-bit history row
// in a single ram with one read and one write port; the row is read when the
// transaction is accepted and written back when the result enters the output
// register. A cell still in flight therefore holds off a new transaction for
// the same cell until its row is written back; distinct cells stream at full
// rate. After reset the block clears all 4 * MAX_EDGE_LENGTH history rows, one
// row per cycle, keeping s_axis_tready low; configuration writes are taken at
// any time. Coefficients are q4.27; the user must write them only while no
// transaction is in flight; the block itself does not enforce this. Positions
// at or beyond MAX_EDGE_LENGTH see a zero history and leave the ram untouched.
// ---------------------------------------------------------------------------
module mur_second_order_abc
    import mabc_pkg::*;
#(
    parameter int MAX_EDGE_LENGTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // slave stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] side, [11:2] position, [43:12] field_depth_one,
    // [75:44] field_depth_two, [79:76] zero
    input  logic [79:0]            s_axis_tdata,
    // master stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] edge_field
    output logic [31:0]            m_axis_tdata,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int HIST_DEPTH = 4 * MAX_EDGE_LENGTH;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int WIDE_W     = ADDR_W + 11;
    localparam int POS_W      = 17;

    // coefficient registers
    word_t weight_zero_reg, weight_one_reg, weight_two_reg;

    // input field unpacking
    logic [1:0]       in_side;
    logic [9:0]       in_position;
    word_t            in_d1, in_d2;
    logic [WIDE_W-1:0] in_addr_wide;
    logic [ADDR_W-1:0] in_addr;
    logic             in_row_valid;

    assign in_side      = s_axis_tdata[1:0];
    assign in_position  = s_axis_tdata[11:2];
    assign in_d1        = s_axis_tdata[43:12];
    assign in_d2        = s_axis_tdata[75:44];
    assign in_addr_wide = WIDE_W'(in_side) * WIDE_W'(MAX_EDGE_LENGTH) + WIDE_W'(in_position);
    assign in_addr      = in_addr_wide[ADDR_W-1:0];
    assign in_row_valid = POS_W'(in_position) < POS_W'(MAX_EDGE_LENGTH);

    // per-stage control: valid bits, row address and row-valid flag
    logic              v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_e_reg;
    logic              v_a_next, v_b_next, v_c_next, v_d_next, v_e_next;
    logic              rv_a_reg, rv_b_reg, rv_c_reg, rv_d_reg;
    logic [ADDR_W-1:0] addr_a_reg, addr_b_reg, addr_c_reg, addr_d_reg;

    // ram clearing pass
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // handshake and stage movement
    logic      rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
    logic      hazard;
    logic      in_accept;
    stage_en_t en;

    // history ram ports
    logic              ram_we, we_pipe;
    logic [ADDR_W-1:0] ram_waddr;
    hist_row_t         ram_wdata, rd_row, wb_row;
    word_t             edge_field;

    // a stage can load when it is empty or its content moves on
    assign rdy_e = !v_e_reg || m_axis_tready;
    assign rdy_d = !v_d_reg || rdy_e;
    assign rdy_c = !v_c_reg || rdy_d;
    assign rdy_b = !v_b_reg || rdy_c;
    assign rdy_a = !v_a_reg || rdy_b;

    // same cell still in flight: its row is not written back yet
    always_comb
    begin
        hazard = in_row_valid && (
                 (v_a_reg && rv_a_reg && addr_a_reg == in_addr) ||
                 (v_b_reg && rv_b_reg && addr_b_reg == in_addr) ||
                 (v_c_reg && rv_c_reg && addr_c_reg == in_addr) ||
                 (v_d_reg && rv_d_reg && addr_d_reg == in_addr));
    end

    assign s_axis_tready = rdy_a && !clr_busy_reg && !hazard;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        en.load_a = in_accept;
        en.load_b = v_a_reg && rdy_b;
        en.load_c = v_b_reg && rdy_c;
        en.load_d = v_c_reg && rdy_d;
        en.load_e = v_d_reg && rdy_e;
    end

    always_comb
    begin
        v_a_next = en.load_a || (v_a_reg && !rdy_b);
        v_b_next = en.load_b || (v_b_reg && !rdy_c);
        v_c_next = en.load_c || (v_c_reg && !rdy_d);
        v_d_next = en.load_d || (v_d_reg && !rdy_e);
        v_e_next = en.load_e || (v_e_reg && !m_axis_tready);
    end

    // write-back happens once, as the result enters the output register
    assign we_pipe   = en.load_e && rv_d_reg;
    assign ram_we    = clr_busy_reg || we_pipe;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : addr_d_reg;
    assign ram_wdata = clr_busy_reg ? hist_row_t'('0) : wb_row;

    assign m_axis_tvalid = v_e_reg;
    assign m_axis_tdata  = edge_field;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg         <= 1'b0;
            v_b_reg         <= 1'b0;
            v_c_reg         <= 1'b0;
            v_d_reg         <= 1'b0;
            v_e_reg         <= 1'b0;
            clr_busy_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            weight_zero_reg <= '0;
            weight_one_reg  <= '0;
            weight_two_reg  <= '0;
        end
        else
        begin
            v_a_reg <= v_a_next;
            v_b_reg <= v_b_next;
            v_c_reg <= v_c_next;
            v_d_reg <= v_d_next;
            v_e_reg <= v_e_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(HIST_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WEIGHT_ZERO: weight_zero_reg <= cfg_data;
                    REG_WEIGHT_ONE:  weight_one_reg  <= cfg_data;
                    REG_WEIGHT_TWO:  weight_two_reg  <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // row address and range flag travel with each transaction
    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            addr_a_reg <= in_addr;
            rv_a_reg   <= in_row_valid;
        end
        if (en.load_b)
        begin
            addr_b_reg <= addr_a_reg;
            rv_b_reg   <= rv_a_reg;
        end
        if (en.load_c)
        begin
            addr_c_reg <= addr_b_reg;
            rv_c_reg   <= rv_b_reg;
        end
        if (en.load_d)
        begin
            addr_d_reg <= addr_c_reg;
            rv_d_reg   <= rv_c_reg;
        end
    end

    mabc_ram #(
        .WIDTH (HIST_ROW_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (in_addr),
        .rdata (rd_row)
    );

    mabc_datapath u_datapath (
        .clk         (clk),
        .en          (en),
        .in_d1       (in_d1),
        .in_d2       (in_d2),
        .row_valid_a (rv_a_reg),
        .rd_row      (rd_row),
        .weight_zero (weight_zero_reg),
        .weight_one  (weight_one_reg),
        .weight_two  (weight_two_reg),
        .wb_row      (wb_row),
        .edge_field  (edge_field)
    );

    // no transaction is taken while the history ram is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !in_accept)
        else $error("transaction accepted during clearing pass");

    // the clearing pass never competes with a write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !(v_d_reg || v_e_reg))
        else $error("pipeline active during clearing pass");

    // one cell is never in flight twice, so no two write-backs in a row hit one row
    assert property (@(posedge clk) disable iff (!rst_n)
        we_pipe |=> !(we_pipe && addr_d_reg == $past(addr_d_reg)))
        else $error("back-to-back write-back to the same history row");

    // an accepted transaction always lands in stage a
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> v_a_reg)
        else $error("accepted transaction lost at stage a");

endmodule

// ===== hdl/mabc_ram.sv =====
// ---------------------------------------------------------------------------
// mabc_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module mabc_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/mabc_datapath.sv =====
// ---------------------------------------------------------------------------
// mabc_datapath: arithmetic pipeline of the boundary update
// pre-sums, three q4.27 products, rounding, final sum and history row build
// ---------------------------------------------------------------------------
module mabc_datapath
    import mabc_pkg::*;
(
    input  logic      clk,
    input  stage_en_t en,
    input  word_t     in_d1,
    input  word_t     in_d2,
    input  logic      row_valid_a,
    input  hist_row_t rd_row,
    input  word_t     weight_zero,
    input  word_t     weight_one,
    input  word_t     weight_two,
    output hist_row_t wb_row,
    output word_t     edge_field
);

    // stage a: item fields, history arrives from the ram
    word_t      a_d1_reg, a_d2_reg;
    // stage b: saturated pre-sums
    word_t      b_s0_reg, b_s1_reg, b_h01_reg, b_h12_reg, b_d1_reg, b_d2_reg;
    hist_step_t b_old_reg;
    // stage c: raw products
    prod_t      c_p0_reg, c_p1_reg, c_p2_reg;
    word_t      c_h12_reg, c_d1_reg, c_d2_reg;
    hist_step_t c_old_reg;
    // stage d: rounded products
    rnd_t       d_r0_reg, d_r1_reg, d_r2_reg;
    word_t      d_h12_reg, d_d1_reg, d_d2_reg;
    hist_step_t d_old_reg;
    // stage e: result
    word_t      e_field_reg;

    hist_row_t                h;
    acc_t                     sum0, sum1, acc;
    logic signed [PROD_W:0]   t0, t1, t2;
    word_t                    e_next;

    always_comb
    begin
        // out-of-range cells see an all-zero history
        h    = row_valid_a ? rd_row : '0;
        sum0 = acc_t'(a_d2_reg) + acc_t'(h.q1.m0);
        sum1 = acc_t'(h.q0.m0) + acc_t'(h.q0.m2) - acc_t'(a_d1_reg) - acc_t'(h.q1.m1);
    end

    always_comb
    begin
        t0 = (PROD_W+1)'(c_p0_reg) + ROUND_BIAS;
        t1 = (PROD_W+1)'(c_p1_reg) + ROUND_BIAS;
        t2 = (PROD_W+1)'(c_p2_reg) + ROUND_BIAS;
    end

    always_comb
    begin
        acc    = acc_t'(d_r0_reg) + acc_t'(d_r1_reg) + acc_t'(d_r2_reg) - acc_t'(d_h12_reg);
        e_next = sat_word(acc);
    end

    always_comb
    begin
        wb_row.q1    = d_old_reg;
        wb_row.q0.m0 = e_next;
        wb_row.q0.m1 = d_d1_reg;
        wb_row.q0.m2 = d_d2_reg;
    end

    assign edge_field = e_field_reg;

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            a_d1_reg <= in_d1;
            a_d2_reg <= in_d2;
        end
        if (en.load_b)
        begin
            b_s0_reg  <= sat_word(sum0);
            b_s1_reg  <= sat_word(sum1);
            b_h01_reg <= h.q0.m1;
            b_h12_reg <= h.q1.m2;
            b_d1_reg  <= a_d1_reg;
            b_d2_reg  <= a_d2_reg;
            b_old_reg <= h.q0;
        end
        if (en.load_c)
        begin
            c_p0_reg  <= prod_t'(weight_zero) * prod_t'(b_s0_reg);
            c_p1_reg  <= prod_t'(weight_one) * prod_t'(b_s1_reg);
            c_p2_reg  <= prod_t'(weight_two) * prod_t'(b_h01_reg);
            c_h12_reg <= b_h12_reg;
            c_d1_reg  <= b_d1_reg;
            c_d2_reg  <= b_d2_reg;
            c_old_reg <= b_old_reg;
        end
        if (en.load_d)
        begin
            // floor shift of the biased product
            d_r0_reg  <= t0[PROD_W:FRAC_BITS];
            d_r1_reg  <= t1[PROD_W:FRAC_BITS];
            d_r2_reg  <= t2[PROD_W:FRAC_BITS];
            d_h12_reg <= c_h12_reg;
            d_d1_reg  <= c_d1_reg;
            d_d2_reg  <= c_d2_reg;
            d_old_reg <= c_old_reg;
        end
        if (en.load_e)
        begin
            e_field_reg <= e_next;
        end
    end

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the mur absorbing boundary block
// drives edge cell transactions with random gaps and back pressure, keeps its
// own copy of the coefficients and the per-cell history, predicts every edge
// field and checks each output transaction against the oldest prediction
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mabc_pkg::*;

    localparam int EDGE_LEN     = 1024;
    localparam int HIST_DEPTH   = 4 * EDGE_LEN * 6;
    // idle cycles with no transaction on any channel before giving up;
    // covers the clearing pass after reset several times over
    localparam int STALL_LIMIT  = 20000;
    // pipeline depth plus margin, waited out once the queue has drained
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    // the fourth register index decodes to nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [79:0]            s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [31:0]            m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [31:0]            cfg_data      = '0;

    mur_second_order_abc #(
        .MAX_EDGE_LENGTH(EDGE_LEN)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // predictor state: coefficients and one history word per
    // (side, position, step back, depth), zero after reset
    // ------------------------------------------------------------------
    word_t coef_zero = '0;
    word_t coef_one  = '0;
    word_t coef_two  = '0;
    word_t cell_history [HIST_DEPTH];

    // predicted edge fields in acceptance order
    word_t edge_expect [$];

    int  mismatches = 0;
    int  stall_count = 0;
    // burst flags switch idling off on one side for a stretch of items
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    int  tx_count = 0;

    // clamp to the signed 32-bit range
    function automatic longint clamp_q427(longint v);
        longint r;
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            r = longint'(32'sh7FFF_FFFF);
        end
        else if (v < -longint'(64'sd2147483648))
        begin
            r = -longint'(64'sd2147483648);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // exact product, then round half up back to q4.27 (floor after the bias)
    function automatic longint q427_product(longint a, longint b);
        longint p;
        p = a * b + (longint'(1) <<< 26);
        return p >>> 27;
    endfunction

    // new edge field for one cell; shifts that cell's history as a side effect
    function automatic word_t mur_update(logic [1:0] side, logic [9:0] pos,
                                         word_t d1, word_t d2);
        longint h [2][3];
        int     base;
        bit     in_range;
        longint sum_a;
        longint sum_b;
        longint acc;
        word_t  e;
        in_range = int'(pos) < EDGE_LEN;
        base = (int'(side) * EDGE_LEN + int'(pos)) * 6;
        for (int q = 0; q < 2; q++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                h[q][m] = in_range ? longint'(cell_history[base + q * 3 + m]) : 0;
            end
        end
        sum_a = clamp_q427(longint'(d2) + h[1][0]);
        sum_b = clamp_q427(h[0][0] + h[0][2] - longint'(d1) - h[1][1]);
        acc = q427_product(longint'(coef_zero), sum_a)
            + q427_product(longint'(coef_one), sum_b)
            + q427_product(longint'(coef_two), h[0][1])
            - h[1][2];
        e = word_t'(clamp_q427(acc));
        if (in_range)
        begin
            for (int m = 0; m < 3; m++)
            begin
                cell_history[base + 3 + m] = cell_history[base + m];
            end
            cell_history[base + 0] = e;
            cell_history[base + 1] = d1;
            cell_history[base + 2] = d2;
        end
        return e;
    endfunction

    // field value: mostly realistic magnitudes, some full range, some extremes
    function automatic word_t draw_word(int kind);
        word_t w;
        case (kind)
            0:       w = word_t'(int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
            1:       w = word_t'($urandom);
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       w = WORD_MIN;
                    1:       w = WORD_MAX;
                    2:       w = '0;
                    3:       w = 32'sd1;
                    default: w = -32'sd1;
                endcase
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------

    // one edge cell transaction; tvalid is left high so that the next call
    // can follow on the very next cycle
    task automatic send_cell(logic [1:0] side, logic [9:0] pos, word_t d1, word_t d2);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, d2, d1, pos, side};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        edge_expect.push_back(mur_update(side, pos, d1, d2));
        tx_count++;
        if (tx_count % 16 == 0)
        begin
            tx_burst = ($urandom_range(0, 2) == 0);
        end
    endtask

    // drop tvalid, wait for every prediction to be met, then let the
    // pipeline run empty before any register write
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (edge_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, word_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (index)
            REG_WEIGHT_ZERO: coef_zero = value;
            REG_WEIGHT_ONE:  coef_one  = value;
            REG_WEIGHT_TWO:  coef_two  = value;
            default:         ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_weights(word_t w0, word_t w1, word_t w2);
        write_reg(REG_WEIGHT_ZERO, w0);
        write_reg(REG_WEIGHT_ONE, w1);
        write_reg(REG_WEIGHT_TWO, w2);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // coefficients at reset are zero, so the edge is minus the depth-two
    // value two steps back; back-to-back on one cell exercises the
    // in-flight hold-off, and negating the minimum saturates
    task automatic test_reset_weights();
        tx_burst = 1'b1;
        send_cell(2'd0, 10'd0, WORD_MAX, WORD_MIN);
        send_cell(2'd0, 10'd0, WORD_MIN, WORD_MAX);
        send_cell(2'd0, 10'd0, '0, '0);
        send_cell(2'd0, 10'd0, '0, '0);
        tx_burst = 1'b0;
        settle();
    endtask

    // each register takes effect; a write to the spare index changes nothing;
    // cells on every side, at one or both ends of the position range
    task automatic test_register_map();
        write_weights(32'sh0800_0000, 32'shF800_0000, 32'sh4000_0000);
        write_reg(REG_SPARE, word_t'($urandom));
        send_cell(2'd0, 10'd1023, draw_word(0), draw_word(0));
        send_cell(2'd1, 10'd0, draw_word(0), draw_word(0));
        send_cell(2'd2, 10'd1023, draw_word(0), draw_word(0));
        send_cell(2'd3, 10'd0, draw_word(0), draw_word(0));
        send_cell(2'd3, 10'd1023, draw_word(1), draw_word(1));
        settle();
        write_reg(REG_SPARE, WORD_MAX);
        send_cell(2'd3, 10'd1023, draw_word(1), draw_word(1));
        settle();
    endtask

    // extreme coefficients against extreme fields: pre-sums and the final
    // sum both clip
    task automatic test_saturation();
        write_weights(WORD_MIN, WORD_MIN, WORD_MIN);
        repeat (3) send_cell(2'd1, 10'd512, WORD_MIN, WORD_MAX);
        settle();
        write_weights(WORD_MAX, WORD_MAX, WORD_MAX);
        send_cell(2'd1, 10'd512, WORD_MAX, WORD_MIN);
        send_cell(2'd1, 10'd512, WORD_MIN, WORD_MIN);
        send_cell(2'd1, 10'd512, WORD_MAX, WORD_MAX);
        settle();
    endtask

    // a coefficient of one half lands products exactly on the half lsb,
    // positive and negative, so round half up is visible
    task automatic test_rounding();
        write_weights(32'sh0400_0000, '0, 32'sd1);
        send_cell(2'd2, 10'd7, '0, 32'sd1);
        send_cell(2'd2, 10'd8, '0, -32'sd1);
        send_cell(2'd2, 10'd9, '0, 32'sd3);
        send_cell(2'd2, 10'd10, '0, -32'sd3);
        settle();
    endtask

    // random phases, each with its own coefficient set; most traffic goes to
    // a small pool of cells so histories build up over many steps
    task automatic test_random();
        logic [1:0] pool_side [8];
        logic [9:0] pool_pos [8];
        logic [1:0] side;
        logic [9:0] pos;
        int         kinds [5];
        kinds = '{0, 1, 2, 0, 1};
        for (int i = 0; i < 8; i++)
        begin
            pool_side[i] = 2'($urandom);
            pool_pos[i]  = 10'($urandom);
        end
        pool_side[0] = 2'd0;
        pool_pos[0]  = 10'd0;
        pool_side[1] = 2'd3;
        pool_pos[1]  = 10'd1023;
        for (int phase = 0; phase < 5; phase++)
        begin
            // phase with kind two puts the coefficients on the extremes
            write_weights(draw_word(kinds[phase]), draw_word(kinds[phase]),
                          draw_word(kinds[phase]));
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_SPARE, word_t'($urandom));
            end
            repeat (100)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    int k;
                    k    = $urandom_range(0, 7);
                    side = pool_side[k];
                    pos  = pool_pos[k];
                end
                else
                begin
                    side = 2'($urandom);
                    pos  = 10'($urandom);
                end
                send_cell(side, pos, draw_word($urandom_range(0, 3) == 3 ? 2 :
                                               $urandom_range(0, 1) == 0 ? 0 : 1),
                          draw_word($urandom_range(0, 3) == 3 ? 2 :
                                    $urandom_range(0, 1) == 0 ? 0 : 1));
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            cell_history[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_weights();
        test_register_map();
        test_saturation();
        test_rounding();
        test_random();
        settle();
        if (mismatches == 0 && edge_expect.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random back pressure, one hold-off draw per transaction
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        int rx_count;
        rx_count = 0;
        forever
        begin
            hold = rx_burst ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (m_axis_tvalid !== 1'b1);
            rx_count++;
            if (rx_count % 16 == 0)
            begin
                rx_burst = ($urandom_range(0, 2) == 0);
            end
        end
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (edge_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected edge_field %h at %0t", m_axis_tdata, $realtime);
                end
            end
            else
            begin
                want = edge_expect.pop_front();
                if (m_axis_tdata !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("edge_field mismatch: expected %h actual %h at %0t",
                                 want, m_axis_tdata, $realtime);
                    end
                end
            end
        end
    end

    // watchdog: too long without a transaction on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            stall_count <= 0;
        end
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            stall_count <= stall_count + 1;
        end
    end

endmodule
